// ===== rtl/jare_pkg.sv =====
package jare_pkg;

    localparam int CHANNELS_DEF       = 4;
    localparam int WARMUP_SAMPLES_DEF = 4;
    localparam int COEF_FRAC_BITS_DEF = 14;

    localparam int RAW_W   = 24;
    localparam int ANGLE_W = 25;
    localparam int DIFF_W  = 26;
    localparam int COEF_W  = 18;
    localparam int RATE_W  = 32;
    localparam int PROD_W  = COEF_W + DIFF_W;
    localparam int FB_W    = COEF_W + RATE_W;
    localparam int ACC_W   = 52;

    localparam int CFG_ADDR_W = 3;

    localparam logic signed [ANGLE_W-1:0] ANGLE_BIAS = 25'sd8192000;

    localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_ONE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_TWO   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFF_GAIN_ZERO = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFF_GAIN_ONE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DIFF_GAIN_TWO  = 3'd4;

    localparam logic signed [COEF_W-1:0] FEEDBACK_ONE_RST   = 18'sd27705;
    localparam logic signed [COEF_W-1:0] FEEDBACK_TWO_RST   = 18'sd12005;
    localparam logic signed [COEF_W-1:0] DIFF_GAIN_ZERO_RST = 18'sd17039;
    localparam logic signed [COEF_W-1:0] DIFF_GAIN_ONE_RST  = 18'sd34243;
    localparam logic signed [COEF_W-1:0] DIFF_GAIN_TWO_RST  = 18'sd17039;

    typedef struct packed {
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
    } coef_t;

    typedef struct packed {
        logic accept;
        logic advance;
        logic fire;
        logic warm;
    } lane_ctrl_t;

endpackage

// ===== rtl/jare_lane.sv =====
module jare_lane #(
    parameter int COEF_FRAC_BITS = jare_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  jare_pkg::lane_ctrl_t                  ctrl,
    input  jare_pkg::coef_t                       coef,
    input  logic        [jare_pkg::RAW_W-1:0]     raw,
    output logic signed [jare_pkg::ANGLE_W-1:0]   angle,
    output logic signed [jare_pkg::RATE_W-1:0]    rate
);

    localparam int ANGLE_W = jare_pkg::ANGLE_W;
    localparam int DIFF_W  = jare_pkg::DIFF_W;
    localparam int PROD_W  = jare_pkg::PROD_W;
    localparam int FB_W    = jare_pkg::FB_W;
    localparam int ACC_W   = jare_pkg::ACC_W;
    localparam int RATE_W  = jare_pkg::RATE_W;
    localparam logic signed [ACC_W-1:0] HALF =
        $signed({{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1));
    localparam logic signed [RATE_W-1:0] RATE_MAX = $signed({1'b0, {(RATE_W-1){1'b1}}});
    localparam logic signed [RATE_W-1:0] RATE_MIN = $signed({1'b1, {(RATE_W-1){1'b0}}});

    logic signed [ANGLE_W-1:0] hist0_reg, hist1_reg, hist2_reg;
    logic signed [ANGLE_W-1:0] x0;
    logic signed [DIFF_W-1:0]  d0_next, d1_next, d2_next;

    logic signed [ANGLE_W-1:0] st1_angle_reg, st2_angle_reg, st3_angle_reg;
    logic signed [DIFF_W-1:0]  st1_d0_reg, st1_d1_reg, st1_d2_reg;
    logic signed [PROD_W-1:0]  st2_p0_reg, st2_p1_reg, st2_p2_reg;
    logic signed [ACC_W-1:0]   st3_ff_reg, ff_next;

    logic signed [RATE_W-1:0]  y1_reg, y2_reg;
    logic signed [FB_W-1:0]    p2_reg, p2_next;
    logic signed [FB_W-1:0]    fb1;
    logic signed [ACC_W-1:0]   acc, shifted;
    logic signed [RATE_W-1:0]  sat;
    logic [ACC_W-RATE_W:0]     top_bits;

    assign x0      = $signed({1'b0, raw}) - jare_pkg::ANGLE_BIAS;
    assign d0_next = {x0[ANGLE_W-1], x0} - {hist0_reg[ANGLE_W-1], hist0_reg};
    assign d1_next = {hist0_reg[ANGLE_W-1], hist0_reg} - {hist1_reg[ANGLE_W-1], hist1_reg};
    assign d2_next = {hist1_reg[ANGLE_W-1], hist1_reg} - {hist2_reg[ANGLE_W-1], hist2_reg};

    assign ff_next = ACC_W'(st2_p0_reg) + ACC_W'(st2_p1_reg) + ACC_W'(st2_p2_reg) + HALF;

    assign fb1      = $signed(coef.a1) * y1_reg;
    assign acc      = st3_ff_reg + ACC_W'(fb1) - ACC_W'(p2_reg);
    assign shifted  = acc >>> COEF_FRAC_BITS;
    assign top_bits = shifted[ACC_W-1:RATE_W-1];

    always_comb
    begin
        priority if (top_bits == '0 || top_bits == '1)
        begin
            sat = shifted[RATE_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            sat = RATE_MIN;
        end
        else
        begin
            sat = RATE_MAX;
        end
    end

    assign p2_next = $signed(coef.a2) * (ctrl.fire ? y1_reg : y2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist0_reg <= '0;
            hist1_reg <= '0;
            hist2_reg <= '0;
            y1_reg    <= '0;
            y2_reg    <= '0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                hist0_reg <= x0;
                hist1_reg <= hist0_reg;
                hist2_reg <= hist1_reg;
            end
            if (ctrl.fire)
            begin
                y1_reg <= sat;
                y2_reg <= y1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p2_reg <= p2_next;
        if (ctrl.advance)
        begin
            st1_angle_reg <= x0;
            st1_d0_reg    <= d0_next;
            st1_d1_reg    <= d1_next;
            st1_d2_reg    <= d2_next;
            st2_angle_reg <= st1_angle_reg;
            st2_p0_reg    <= $signed(coef.b0) * st1_d0_reg;
            st2_p1_reg    <= $signed(coef.b1) * st1_d1_reg;
            st2_p2_reg    <= $signed(coef.b2) * st1_d2_reg;
            st3_angle_reg <= st2_angle_reg;
            st3_ff_reg    <= ff_next;
        end
    end

    assign angle = st3_angle_reg;
    assign rate  = ctrl.warm ? sat : '0;

endmodule

// ===== rtl/jare_merge.sv =====
module jare_merge #(
    parameter int CHANNELS    = jare_pkg::CHANNELS_DEF,
    parameter int OUT_TDATA_W = 232
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    input  logic                                    rate_valid,
    input  logic [CHANNELS*jare_pkg::ANGLE_W-1:0]   angles,
    input  logic [CHANNELS*jare_pkg::RATE_W-1:0]    rates,
    input  logic                                    m_axis_tready,
    output logic                                    m_axis_tvalid,
    output logic [OUT_TDATA_W-1:0]                  m_axis_tdata,
    output logic [0:0]                              m_axis_tuser,
    output logic                                    advance
);

    logic                   tvalid_reg;
    logic [OUT_TDATA_W-1:0] tdata_reg;
    logic                   tuser_reg;

    assign advance = !tvalid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tvalid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            tdata_reg <= OUT_TDATA_W'({rates, angles});
            tuser_reg <= rate_valid;
        end
    end

    assign m_axis_tvalid   = tvalid_reg;
    assign m_axis_tdata    = tdata_reg;
    assign m_axis_tuser[0] = tuser_reg;

endmodule

// ===== rtl/joint_angle_rate_estimator.sv =====
// Joint angle and rate estimator for CHANNELS joint channels.
// Input stream: each item carries one raw 24-bit angle count per channel.
// Output stream: each item carries every channel's angle (raw minus 250
// degrees, 2^-15 degree units) and its rate from a second-order IIR
// differentiator with Q-format coefficients, saturated to 32 bits.
// tuser flags whether the rates are valid; the first WARMUP_SAMPLES items
// after reset carry zero rates and a clear flag.
// An item goes through lane stages st1, st2, st3, then the output register.
// Throughput: one item per cycle while the output is not stalled; the limit
// is the rate feedback loop of each lane (one multiply, add, round and
// saturate between the rate registers).
// The lanes run in lockstep; the merge stage packs their results into one
// output register. When the receiver stalls, the pipeline holds and
// s_axis_tready falls only while a result waits and the output cannot take
// the next one.
// Reset clears the angle and rate history, the warm-up count and all
// valid flags, and loads the default coefficients.
// Coefficients are written through cfg_wr_en/cfg_addr/cfg_data while idle.
module joint_angle_rate_estimator #(
    parameter  int CHANNELS       = jare_pkg::CHANNELS_DEF,
    parameter  int WARMUP_SAMPLES = jare_pkg::WARMUP_SAMPLES_DEF,
    parameter  int COEF_FRAC_BITS = jare_pkg::COEF_FRAC_BITS_DEF,
    localparam int IN_TDATA_W     = ((CHANNELS * jare_pkg::RAW_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W    =
        ((CHANNELS * (jare_pkg::ANGLE_W + jare_pkg::RATE_W) + 7) / 8) * 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [jare_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [jare_pkg::COEF_W-1:0]           cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // raw count of each channel, 24 bits each, channel 0 lowest
    input  logic [IN_TDATA_W-1:0]                 s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // angle of each channel (25 bits), then rate of each channel (32 bits)
    output logic [OUT_TDATA_W-1:0]                m_axis_tdata,
    // rate_valid
    output logic [0:0]                            m_axis_tuser
);

    localparam int WARM_W  = $clog2(WARMUP_SAMPLES + 1);
    localparam int ANGLE_W = jare_pkg::ANGLE_W;
    localparam int RATE_W  = jare_pkg::RATE_W;
    localparam int RAW_W   = jare_pkg::RAW_W;

    jare_pkg::coef_t      coef_reg;
    jare_pkg::lane_ctrl_t ctrl;

    logic              advance;
    logic              accept;
    logic [WARM_W-1:0] warm_cnt_reg, warm_cnt_next;
    logic              warm_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic              w1_reg, w2_reg, w3_reg;

    logic [CHANNELS*ANGLE_W-1:0] angles;
    logic [CHANNELS*RATE_W-1:0]  rates;

    assign accept        = s_axis_tvalid && advance;
    assign s_axis_tready = advance;
    assign warm_cnt_next = warm_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.a1 <= jare_pkg::FEEDBACK_ONE_RST;
            coef_reg.a2 <= jare_pkg::FEEDBACK_TWO_RST;
            coef_reg.b0 <= jare_pkg::DIFF_GAIN_ZERO_RST;
            coef_reg.b1 <= jare_pkg::DIFF_GAIN_ONE_RST;
            coef_reg.b2 <= jare_pkg::DIFF_GAIN_TWO_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                jare_pkg::REG_FEEDBACK_ONE:   coef_reg.a1 <= cfg_data;
                jare_pkg::REG_FEEDBACK_TWO:   coef_reg.a2 <= cfg_data;
                jare_pkg::REG_DIFF_GAIN_ZERO: coef_reg.b0 <= cfg_data;
                jare_pkg::REG_DIFF_GAIN_ONE:  coef_reg.b1 <= cfg_data;
                jare_pkg::REG_DIFF_GAIN_TWO:  coef_reg.b2 <= cfg_data;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_cnt_reg <= '0;
            warm_reg     <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            w1_reg       <= 1'b0;
            w2_reg       <= 1'b0;
            w3_reg       <= 1'b0;
        end
        else
        begin
            if (accept && !warm_reg)
            begin
                warm_cnt_reg <= warm_cnt_next;
                if (warm_cnt_next >= WARM_W'(WARMUP_SAMPLES))
                begin
                    warm_reg <= 1'b1;
                end
            end
            if (advance)
            begin
                v1_reg <= s_axis_tvalid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                w1_reg <= warm_reg;
                w2_reg <= w1_reg;
                w3_reg <= w2_reg;
            end
        end
    end

    assign ctrl.accept  = accept;
    assign ctrl.advance = advance;
    assign ctrl.fire    = advance && v3_reg && w3_reg;
    assign ctrl.warm    = w3_reg;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        logic signed [ANGLE_W-1:0] lane_angle;
        logic signed [RATE_W-1:0]  lane_rate;

        jare_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .coef  (coef_reg),
            .raw   (s_axis_tdata[c*RAW_W +: RAW_W]),
            .angle (lane_angle),
            .rate  (lane_rate)
        );

        assign angles[c*ANGLE_W +: ANGLE_W] = lane_angle;
        assign rates[c*RATE_W +: RATE_W]    = lane_rate;
    end

    jare_merge #(
        .CHANNELS    (CHANNELS),
        .OUT_TDATA_W (OUT_TDATA_W)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (v3_reg),
        .rate_valid    (w3_reg),
        .angles        (angles),
        .rates         (rates),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .advance       (advance)
    );

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jare_pkg::*;

    localparam int CH          = CHANNELS_DEF;
    localparam int IN_W        = ((CH * RAW_W + 7) / 8) * 8;
    localparam int WORD_W      = CH * (ANGLE_W + RATE_W);
    localparam int OUT_W       = ((WORD_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT = 4000;

    localparam longint RATE_MAX   = 64'sd2147483647;
    localparam longint RATE_MIN   = -64'sd2147483648;
    localparam longint ROUND_HALF = 64'sd1 <<< (COEF_FRAC_BITS_DEF - 1);

    localparam logic [COEF_W-1:0] COEF_MAX = 18'h1FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 18'h20000;
    localparam logic [COEF_W-1:0] COEF_ZERO = 18'h00000;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic [RAW_W-1:0] RAW_TOP = 24'hFFFFFF;
    localparam logic [RAW_W-1:0] RAW_ZERO_DEG = 24'd8192000;

    typedef logic [CH-1:0][RAW_W-1:0] raw_set_t;

    typedef struct packed {
        logic [CH-1:0][RATE_W-1:0]  rate;
        logic [CH-1:0][ANGLE_W-1:0] angle;
    } joint_word_t;

    typedef struct packed {
        logic        rate_ok;
        joint_word_t word;
    } estimate_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [COEF_W-1:0]     cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    coef_t gains = '{a1: FEEDBACK_ONE_RST, a2: FEEDBACK_TWO_RST, b0: DIFF_GAIN_ZERO_RST,
                     b1: DIFF_GAIN_ONE_RST, b2: DIFF_GAIN_TWO_RST};
    logic signed [ANGLE_W-1:0] angle_trail [CH][3] = '{default: '0};
    logic signed [RATE_W-1:0]  rate_trail [CH][2] = '{default: '0};
    int unsigned               warm_count = 0;
    bit                        warmed_up = 1'b0;

    estimate_t   pending_estimates [$];
    raw_set_t    path_raw = '0;
    bit          jitter_on = 1'b0;
    int unsigned sink_stall = 0;
    int unsigned quiet_cycles = 0;

    int unsigned mismatch_count = 0;
    int unsigned samples_sent = 0;
    int unsigned estimates_checked = 0;
    int unsigned saturated_rates = 0;
    int unsigned gain_settings = 0;
    int unsigned unused_writes = 0;

    joint_angle_rate_estimator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial forever #6 clk = ~clk;

    task automatic predict_joint_sample(input raw_set_t raw);
        estimate_t                est;
        longint                   x0;
        longint                   acc;
        longint                   q;
        logic signed [RATE_W-1:0] r;
        est = '0;
        est.rate_ok = warmed_up;
        for (int c = 0; c < CH; c++)
        begin
            x0 = longint'(raw[c]) - longint'(ANGLE_BIAS);
            r = '0;
            if (warmed_up)
            begin
                acc = longint'(gains.a1) * longint'(rate_trail[c][0])
                    - longint'(gains.a2) * longint'(rate_trail[c][1])
                    + longint'(gains.b0) * (x0 - longint'(angle_trail[c][0]))
                    + longint'(gains.b1)
                      * (longint'(angle_trail[c][0]) - longint'(angle_trail[c][1]))
                    + longint'(gains.b2)
                      * (longint'(angle_trail[c][1]) - longint'(angle_trail[c][2]));
                q = (acc + ROUND_HALF) >>> COEF_FRAC_BITS_DEF;
                if (q > RATE_MAX)
                begin
                    r = RATE_MAX[RATE_W-1:0];
                    saturated_rates++;
                end
                else if (q < RATE_MIN)
                begin
                    r = RATE_MIN[RATE_W-1:0];
                    saturated_rates++;
                end
                else
                begin
                    r = q[RATE_W-1:0];
                end
                rate_trail[c][1] = rate_trail[c][0];
                rate_trail[c][0] = r;
            end
            angle_trail[c][2] = angle_trail[c][1];
            angle_trail[c][1] = angle_trail[c][0];
            angle_trail[c][0] = x0[ANGLE_W-1:0];
            est.word.angle[c] = x0[ANGLE_W-1:0];
            est.word.rate[c] = r;
        end
        if (!warmed_up)
        begin
            warm_count++;
            if (warm_count >= WARMUP_SAMPLES_DEF)
                warmed_up = 1'b1;
        end
        pending_estimates = {pending_estimates, est};
    endtask

    task automatic send_sample(input raw_set_t raw);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(raw);
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_joint_sample(raw);
        samples_sent++;
        if (jitter_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [COEF_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (addr)
            REG_FEEDBACK_ONE:   gains.a1 = data;
            REG_FEEDBACK_TWO:   gains.a2 = data;
            REG_DIFF_GAIN_ZERO: gains.b0 = data;
            REG_DIFF_GAIN_ONE:  gains.b1 = data;
            REG_DIFF_GAIN_TWO:  gains.b2 = data;
            default:            unused_writes++;
        endcase
    endtask

    task automatic program_gains(input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2,
                                 input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                                 input logic [COEF_W-1:0] b2);
        wait_idle();
        write_reg(REG_FEEDBACK_ONE, a1);
        write_reg(REG_FEEDBACK_TWO, a2);
        write_reg(REG_DIFF_GAIN_ZERO, b0);
        write_reg(REG_DIFF_GAIN_ONE, b1);
        write_reg(REG_DIFF_GAIN_TWO, b2);
        gain_settings++;
    endtask

    function automatic logic [COEF_W-1:0] any_coef();
        return COEF_W'($urandom);
    endfunction

    function automatic logic [COEF_W-1:0] near_coef(input logic signed [COEF_W-1:0] center,
                                                    input int unsigned spread);
        return COEF_W'(int'(center) + int'($urandom_range(0, 2 * spread)) - int'(spread));
    endfunction

    function automatic logic [COEF_W-1:0] edge_coef();
        case ($urandom_range(0, 2))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            default: return COEF_ZERO;
        endcase
    endfunction

    // mostly smooth joint motion, with jumps, rail values and held samples mixed in
    function automatic raw_set_t draw_sample(input int unsigned step);
        raw_set_t    s;
        int unsigned kind;
        for (int c = 0; c < CH; c++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                s[c] = path_raw[c] + RAW_W'($urandom_range(0, 2 * step)) - RAW_W'(step);
            else if (kind < 8)
                s[c] = RAW_W'($urandom);
            else if (kind < 9)
                s[c] = $urandom_range(0, 1) ? RAW_TOP : '0;
            else
                s[c] = path_raw[c];
            path_raw[c] = s[c];
        end
        return s;
    endfunction

    task automatic test_warmup_extremes();
        send_sample('0);
        send_sample({CH{RAW_TOP}});
        send_sample({CH{RAW_ZERO_DEG}});
        send_sample({RAW_ZERO_DEG + 24'd1, RAW_ZERO_DEG - 24'd1, RAW_TOP, 24'd0});
        send_sample({RAW_TOP, 24'd0, RAW_TOP, 24'd0});
        send_sample({24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555});
        send_sample({24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA});
        for (int i = 0; i < 3; i++)
            send_sample({CH{RAW_ZERO_DEG + RAW_W'(1000 * i)}});
    endtask

    task automatic test_coef_extremes();
        program_gains(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample('0);
        send_sample({CH{RAW_TOP}});
        send_sample('0);
        send_sample({CH{RAW_TOP}});
        program_gains(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample({RAW_TOP, 24'd0, RAW_TOP, 24'd0});
        send_sample({24'd0, RAW_TOP, 24'd0, RAW_TOP});
        send_sample({RAW_TOP, 24'd0, RAW_TOP, 24'd0});
        program_gains(COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        send_sample({CH{RAW_TOP}});
        send_sample('0);
        wait_idle();
        for (logic [CFG_ADDR_W-1:0] a = REG_UNUSED_LO; a != REG_FEEDBACK_ONE; a++)
            write_reg(a, any_coef());
        send_sample({CH{RAW_ZERO_DEG}});
        send_sample({CH{RAW_TOP}});
    endtask

    task automatic test_random_settings();
        int unsigned step;
        jitter_on = 1'b1;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: program_gains(near_coef(FEEDBACK_ONE_RST, 2000),
                                 near_coef(FEEDBACK_TWO_RST, 2000),
                                 near_coef(DIFF_GAIN_ZERO_RST, 2000),
                                 near_coef(DIFF_GAIN_ONE_RST, 2000),
                                 near_coef(DIFF_GAIN_TWO_RST, 2000));
                1: program_gains(any_coef(), any_coef(), any_coef(), any_coef(), any_coef());
                2: program_gains(near_coef(18'sd8192, 8192), near_coef(18'sd4096, 4096),
                                 near_coef('0, 4096), near_coef('0, 4096),
                                 near_coef('0, 4096));
                default: program_gains(edge_coef(), edge_coef(), edge_coef(), edge_coef(),
                                       edge_coef());
            endcase
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_ADDR_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          any_coef());
            step = 1 << $urandom_range(0, 20);
            for (int i = 0; i < 170; i++)
            begin
                if (i == 85)
                    wait_idle();
                send_sample(draw_sample(step));
            end
        end
    endtask

    task automatic test_back_to_back();
        program_gains(any_coef(), any_coef(), any_coef(), any_coef(), any_coef());
        jitter_on = 1'b0;
        for (int i = 0; i < 140; i++)
            send_sample(draw_sample(1 << 12));
    endtask

    always @(posedge clk)
    begin
        if (sink_stall != 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall <= $urandom_range(0, 10);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        estimate_t   want;
        joint_word_t seen;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_estimates.size() == 0)
            begin
                $display("%0t: result with nothing expected, tdata %h", $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_estimates.pop_front();
                seen = joint_word_t'(m_axis_tdata[WORD_W-1:0]);
                estimates_checked++;
                for (int c = 0; c < CH; c++)
                begin
                    if (seen.angle[c] !== want.word.angle[c])
                    begin
                        $display("%0t: angle %0d expected %0d got %0d", $time, c,
                                 $signed(want.word.angle[c]), $signed(seen.angle[c]));
                        mismatch_count++;
                    end
                    if (seen.rate[c] !== want.word.rate[c])
                    begin
                        $display("%0t: rate %0d expected %0d got %0d", $time, c,
                                 $signed(want.word.rate[c]), $signed(seen.rate[c]));
                        mismatch_count++;
                    end
                end
                if (m_axis_tuser[0] !== want.rate_ok)
                begin
                    $display("%0t: rate_valid expected %b got %b", $time, want.rate_ok,
                             m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("joint_angle_rate_estimator verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_warmup_extremes();
        test_coef_extremes();
        test_random_settings();
        test_back_to_back();
        wait_idle();
        $display("covered %0d samples under %0d gain settings, %0d results checked",
                 samples_sent, gain_settings, estimates_checked);
        $display("%0d rates hit the saturation rails, %0d writes went to unused indexes",
                 saturated_rates, unused_writes);
        if (mismatch_count == 0)
            $display("joint_angle_rate_estimator verification clean");
        else
            $display("joint_angle_rate_estimator verification failed");
        $finish;
    end

endmodule
